// ===== rtl/tfr_pkg.sv =====
// ----------------------------------------------------------------------------
// tfr_pkg
// Shared types and constants of the thread FIFO with removal by id.
// ----------------------------------------------------------------------------
package tfr_pkg;

    localparam int TFR_DEPTH_DEF = 16;
    localparam int HANDLE_W      = 16;
    localparam int ID_W          = 16;
    localparam int COUNT_OUT_W   = 5;
    localparam int ENTRY_W       = HANDLE_W + ID_W;

    typedef enum logic [1:0] {
        MODE_ENQ = 2'd0,
        MODE_DEQ = 2'd1,
        MODE_REM = 2'd2,
        MODE_NOP = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

endpackage

// ===== rtl/tfr_ram.sv =====
// ----------------------------------------------------------------------------
// tfr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tfr_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/thread_fifo_with_removal_unit.sv =====
// ----------------------------------------------------------------------------
// thread_fifo_with_removal_unit
// Bounded FIFO of {handle, id} entries held in one circular RAM, with
// enqueue, dequeue of the head and removal of the first entry matching an id.
// ----------------------------------------------------------------------------
// Flow: enqueue, empty-FIFO cases and the unused mode go from the accept
//   straight to S_FIN; a dequeue passes through S_DEQ for the head read; a
//   removal on a nonempty FIFO passes through S_SCAN, one RAM read per held entry plus read return.
// Throughput: one item per operation; the next item is taken once the
//   previous one has finished and its result sits in the output register.
// Reset: clears head, count, state and output valid; RAM contents are kept.
// ----------------------------------------------------------------------------
module thread_fifo_with_removal_unit
    import tfr_pkg::*;
#(
    parameter int DEPTH = TFR_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input item
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] thread_handle, [31:16] thread_id
    input  logic [1:0]  s_tuser,   // [1:0] mode
    // result item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] handle_out, [20:16] count_now, [23:21] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_DEQ  = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    // Circular address: base plus offset, both below DEPTH, wrapped once.
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_W)
        begin
            sum = sum - DEPTH_W;
        end
        return sum[AW-1:0];
    endfunction

    state_t             state_reg, state_next;
    logic [AW-1:0]      head_reg, head_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    // scan control: issued read offset, returning read, match seen
    logic [CW-1:0]      iss_reg, iss_next;
    logic               rv_reg, rv_next;
    logic [AW-1:0]      roff_reg, roff_next;
    logic               found_reg, found_next;
    logic [ID_W-1:0]    tid_reg, tid_next;
    // pending result
    logic [HANDLE_W-1:0] hout_reg, hout_next;
    status_t            status_reg, status_next;
    // output register
    logic               ovalid_reg, ovalid_next;
    logic [HANDLE_W-1:0] oh_reg, oh_next;
    status_t            ost_reg, ost_next;
    logic [COUNT_OUT_W-1:0] ocnt_reg, ocnt_next;

    // RAM ports
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    logic               in_acc;
    mode_t              in_mode;
    logic [HANDLE_W-1:0] in_handle;
    logic [ID_W-1:0]    in_id;
    logic [HANDLE_W-1:0] rd_handle;
    logic [ID_W-1:0]    rd_id;
    logic               out_free;
    logic [CW+COUNT_OUT_W-1:0] cnt_wide;

    assign in_mode   = mode_t'(s_tuser);
    assign in_handle = s_tdata[15:0];
    assign in_id     = s_tdata[31:16];
    assign rd_id     = ram_rdata[ID_W-1:0];
    assign rd_handle = ram_rdata[ENTRY_W-1:ID_W];

    assign s_tready  = (state_reg == S_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign out_free  = !ovalid_reg || m_tready;
    // count reported masked to the output field width
    assign cnt_wide  = {{COUNT_OUT_W{1'b0}}, cnt_reg};

    assign m_tvalid  = ovalid_reg;
    assign m_tdata   = {3'b000, ocnt_reg, oh_reg};
    assign m_tuser   = ost_reg;

    tfr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        cnt_next    = cnt_reg;
        iss_next    = iss_reg;
        rv_next     = 1'b0;
        roff_next   = roff_reg;
        found_next  = found_reg;
        tid_next    = tid_reg;
        hout_next   = hout_reg;
        status_next = status_reg;
        ovalid_next = ovalid_reg && !m_tready;
        oh_next     = oh_reg;
        ost_next    = ost_reg;
        ocnt_next   = ocnt_reg;

        ram_we      = 1'b0;
        ram_waddr   = wrap_add(head_reg, cnt_reg[AW-1:0]);
        ram_wdata   = {in_handle, in_id};
        ram_raddr   = head_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    hout_next   = '0;
                    status_next = ST_OK;
                    state_next  = S_FIN;
                    unique case (in_mode)
                        MODE_ENQ:
                        begin
                            if (cnt_reg >= DEPTH_C)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                // append at the tail
                                ram_we   = 1'b1;
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        MODE_DEQ:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                // read address is the head already
                                state_next = S_DEQ;
                            end
                        end
                        MODE_REM:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                            else
                            begin
                                iss_next   = '0;
                                found_next = 1'b0;
                                tid_next   = in_id;
                                state_next = S_SCAN;
                            end
                        end
                        MODE_NOP:
                        begin
                            status_next = ST_OK;
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end

            S_DEQ:
            begin
                // head data is back: drop the head entry
                hout_next  = rd_handle;
                head_next  = wrap_add(head_reg, AW'(1));
                cnt_next   = cnt_reg - 1'b1;
                state_next = S_FIN;
            end

            S_SCAN:
            begin
                // issue one read per cycle, head to tail
                ram_raddr = wrap_add(head_reg, iss_reg[AW-1:0]);
                if (iss_reg < cnt_reg)
                begin
                    rv_next   = 1'b1;
                    roff_next = iss_reg[AW-1:0];
                    iss_next  = iss_reg + 1'b1;
                end

                // handle the returning entry: compare, or shift down one slot
                if (rv_reg)
                begin
                    if (!found_reg)
                    begin
                        if (rd_id == tid_reg)
                        begin
                            found_next = 1'b1;
                            hout_next  = rd_handle;
                        end
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = wrap_add(head_reg, roff_reg - 1'b1);
                        ram_wdata = ram_rdata;
                    end
                end

                // all reads issued and returned
                if ((iss_reg == cnt_reg) && !rv_reg)
                begin
                    if (found_reg)
                    begin
                        cnt_next    = cnt_reg - 1'b1;
                        status_next = ST_OK;
                    end
                    else
                    begin
                        hout_next   = '0;
                        status_next = ST_NOT_FOUND;
                    end
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    oh_next     = hout_reg;
                    ost_next    = status_reg;
                    ocnt_next   = cnt_wide[COUNT_OUT_W-1:0];
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            cnt_reg    <= '0;
            iss_reg    <= '0;
            rv_reg     <= 1'b0;
            found_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            cnt_reg    <= cnt_next;
            iss_reg    <= iss_next;
            rv_reg     <= rv_next;
            found_reg  <= found_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        roff_reg   <= roff_next;
        tid_reg    <= tid_next;
        hout_reg   <= hout_next;
        status_reg <= status_next;
        oh_reg     <= oh_next;
        ost_reg    <= ost_next;
        ocnt_reg   <= ocnt_next;
    end

endmodule
